FILE: sv/spfc_pkg.sv
// Shared types, codes and reset constants for the supply front panel controller.
package spfc_pkg;

    localparam int CfgIndexWidth = 3;

    localparam logic [15:0] VoltageMaxReset     = 16'd30;
    localparam logic [15:0] VoltageMinReset     = 16'd0;
    localparam logic [15:0] CurrentMaxReset     = 16'd3000;
    localparam logic [15:0] CurrentMinReset     = 16'd0;
    localparam logic [15:0] TripHoldTicksReset  = 16'd100;
    localparam logic [15:0] VoltageDefaultReset = 16'd5;
    localparam logic [15:0] CurrentDefaultReset = 16'd350;

    typedef enum logic [2:0] {
        MODE_STANDBY = 3'd0,
        MODE_MENU    = 3'd1,
        MODE_POWERED = 3'd2,
        MODE_TRIPPED = 3'd3,
        MODE_CURCFG  = 3'd4,
        MODE_VOLTCFG = 3'd5,
        MODE_ONCUR   = 3'd6,
        MODE_ONVOLT  = 3'd7
    } mode_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_VOLTAGE_MAX     = 3'd0,
        CFG_VOLTAGE_MIN     = 3'd1,
        CFG_CURRENT_MAX     = 3'd2,
        CFG_CURRENT_MIN     = 3'd3,
        CFG_TRIP_HOLD_TICKS = 3'd4,
        CFG_VOLTAGE_DEFAULT = 3'd5,
        CFG_CURRENT_DEFAULT = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] voltage_max;
        logic [15:0] voltage_min;
        logic [15:0] current_max;
        logic [15:0] current_min;
        logic [15:0] trip_hold_ticks;
        logic [15:0] voltage_default;
        logic [15:0] current_default;
    } cfg_t;

    typedef struct packed {
        logic switch_on;
        logic overcurrent;
        logic press_enter;
        logic press_up;
        logic press_down;
        logic press_back;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        relay_closed;
        logic        standby_lamp;
        logic        output_lamp;
        logic        trip_lamp;
        logic        glow_red;
        logic        glow_green;
        logic        glow_blue;
        logic [15:0] voltage_setpoint;
        logic [15:0] current_setpoint;
    } out_item_t;

    typedef struct packed {
        logic blue;
        logic green;
        logic red;
        logic trip;
        logic out;
        logic stby;
        logic relay;
    } ind_t;

    typedef struct packed {
        mode_t       mode;
        logic        entry_pending;
        logic [15:0] hold_count;
        logic [15:0] volt_set;
        logic [15:0] amp_set;
        ind_t        ind;
    } panel_state_t;

endpackage

FILE: sv/spfc_cfg_regs.sv
// Configuration register file: clamps, trip hold time and setpoint defaults.
module spfc_cfg_regs
    import spfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [CfgIndexWidth-1:0] wr_index,
    input  logic [15:0]              wr_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_VOLTAGE_MAX:     cfg_next.voltage_max     = wr_data;
                CFG_VOLTAGE_MIN:     cfg_next.voltage_min     = wr_data;
                CFG_CURRENT_MAX:     cfg_next.current_max     = wr_data;
                CFG_CURRENT_MIN:     cfg_next.current_min     = wr_data;
                CFG_TRIP_HOLD_TICKS: cfg_next.trip_hold_ticks = wr_data;
                CFG_VOLTAGE_DEFAULT: cfg_next.voltage_default = wr_data;
                CFG_CURRENT_DEFAULT: cfg_next.current_default = wr_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voltage_max     <= VoltageMaxReset;
            cfg_reg.voltage_min     <= VoltageMinReset;
            cfg_reg.current_max     <= CurrentMaxReset;
            cfg_reg.current_min     <= CurrentMinReset;
            cfg_reg.trip_hold_ticks <= TripHoldTicksReset;
            cfg_reg.voltage_default <= VoltageDefaultReset;
            cfg_reg.current_default <= CurrentDefaultReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/spfc_step.sv
// Per-tick next-state logic: trip, switch, mode actions, setpoint steps.
module spfc_step
    import spfc_pkg::*;
(
    input  cfg_t         cfg,
    input  in_item_t     item,
    input  panel_state_t cur,
    output panel_state_t nxt
);

    mode_t       m;
    ind_t        ind;
    logic [15:0] volt;
    logic [15:0] amp;
    logic [15:0] hold;

    always_comb
    begin
        m    = cur.mode;
        ind  = cur.ind;
        volt = cur.volt_set;
        amp  = cur.amp_set;
        hold = cur.hold_count;

        // Trip only from energised modes, and open the relay at once.
        if (item.overcurrent && (m == MODE_POWERED || m == MODE_ONCUR || m == MODE_ONVOLT))
        begin
            m         = MODE_TRIPPED;
            ind.relay = 1'b0;
        end
        if (!item.switch_on)
        begin
            m = MODE_STANDBY;
        end

        case (m)
            MODE_STANDBY:
            begin
                if (cur.entry_pending)
                begin
                    ind      = '0;
                    ind.stby = 1'b1;
                    volt     = cfg.voltage_default;
                    amp      = cfg.current_default;
                end
                if (item.switch_on)
                begin
                    m = MODE_MENU;
                end
            end
            MODE_MENU:
            begin
                if (cur.entry_pending)
                begin
                    ind      = '0;
                    ind.blue = 1'b1;
                end
                if (item.press_enter) m = MODE_POWERED;
                if (item.press_up)    m = MODE_VOLTCFG;
                if (item.press_down)  m = MODE_CURCFG;
            end
            MODE_POWERED:
            begin
                if (cur.entry_pending)
                begin
                    ind       = '0;
                    ind.out   = 1'b1;
                    ind.relay = 1'b1;
                    ind.green = 1'b1;
                end
                if (item.press_enter) m = MODE_MENU;
                if (item.press_up)    m = MODE_ONVOLT;
                if (item.press_down)  m = MODE_ONCUR;
                if (item.press_back)  m = MODE_MENU;
            end
            MODE_TRIPPED:
            begin
                if (cur.entry_pending)
                begin
                    ind      = '0;
                    ind.trip = 1'b1;
                    ind.red  = 1'b1;
                end
                if (hold != 16'hFFFF)
                begin
                    hold = hold + 16'd1;
                end
                if (hold >= cfg.trip_hold_ticks)
                begin
                    m = MODE_MENU;
                end
            end
            MODE_CURCFG, MODE_ONCUR:
            begin
                if (item.press_up && amp < cfg.current_max)
                begin
                    amp = amp + 16'd1;
                end
                if (item.press_down && amp > cfg.current_min)
                begin
                    amp = amp - 16'd1;
                end
                if (m == MODE_CURCFG)
                begin
                    if (item.press_back)  m = MODE_MENU;
                    if (item.press_enter) m = MODE_POWERED;
                end
                else
                begin
                    if (item.press_back)  m = MODE_POWERED;
                    if (item.press_enter) m = MODE_MENU;
                end
            end
            default:
            begin
                // voltage config, offline and online
                if (item.press_up && volt < cfg.voltage_max)
                begin
                    volt = volt + 16'd1;
                end
                if (item.press_down && volt > cfg.voltage_min)
                begin
                    volt = volt - 16'd1;
                end
                if (m == MODE_VOLTCFG)
                begin
                    if (item.press_back)  m = MODE_MENU;
                    if (item.press_enter) m = MODE_POWERED;
                end
                else
                begin
                    if (item.press_back)  m = MODE_POWERED;
                    if (item.press_enter) m = MODE_MENU;
                end
            end
        endcase

        nxt.mode          = m;
        nxt.ind           = ind;
        nxt.volt_set      = volt;
        nxt.amp_set       = amp;
        nxt.entry_pending = (m != cur.mode);
        nxt.hold_count    = (m != cur.mode) ? 16'd0 : hold;
    end

endmodule

FILE: sv/supply_front_panel_controller_top.sv
// Top level of the supply front panel controller: stages, state and config.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_data   (in_item_t, one tick)
//  out      output     out_valid / out_stall  out_data  (out_item_t, one per tick)
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out is not stalled; each item waits in the input register
// and its result is registered in the result register as the item advances.
// The panel state register updates as the item leaves the input register.
// Reset puts the mode in standby with its entry action due and loads default config.
// A stall on out holds the result register and backs up into in_stall; cfg_ready is
// always high.
module supply_front_panel_controller_top
    import spfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_item_t                out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [15:0]              cfg_data
);

    cfg_t         cfg;
    in_item_t     item_reg;
    logic         item_valid_reg;
    panel_state_t st_reg;
    panel_state_t st_next;
    out_item_t    res_reg;
    out_item_t    res_next;
    logic         res_valid_reg;
    logic         advance;

    assign cfg_ready = 1'b1;

    spfc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    spfc_step u_step (
        .cfg  (cfg),
        .item (item_reg),
        .cur  (st_reg),
        .nxt  (st_next)
    );

    // Advance when the result slot is free or is being taken.
    assign advance  = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;

    always_comb
    begin
        res_next.mode             = st_next.mode;
        res_next.relay_closed     = st_next.ind.relay;
        res_next.standby_lamp     = st_next.ind.stby;
        res_next.output_lamp      = st_next.ind.out;
        res_next.trip_lamp        = st_next.ind.trip;
        res_next.glow_red         = st_next.ind.red;
        res_next.glow_green       = st_next.ind.green;
        res_next.glow_blue        = st_next.ind.blue;
        res_next.voltage_setpoint = st_next.volt_set;
        res_next.current_setpoint = st_next.amp_set;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            st_reg.mode          <= MODE_STANDBY;
            st_reg.entry_pending <= 1'b1;
            st_reg.hold_count    <= '0;
            st_reg.volt_set      <= '0;
            st_reg.amp_set       <= '0;
            st_reg.ind           <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                st_reg        <= st_next;
                res_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            item_reg <= in_data;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

`ifndef SYNTH
    a_hold_only_tripped: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.hold_count != 16'd0 |-> st_reg.mode == MODE_TRIPPED)
        else $error("hold count nonzero outside tripped mode");

    a_entry_tracks_change: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> st_reg.entry_pending == (st_reg.mode != $past(st_reg.mode)))
        else $error("entry action flag does not match mode change");

    a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("advanced item produced no result");

    a_tripped_relay_open: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.mode == MODE_TRIPPED |-> !res_reg.relay_closed)
        else $error("relay closed in tripped mode");
`endif

endmodule

FILE: tb/supply_front_panel_controller_top_tb.sv
// Self-checking testbench for the supply front panel controller top level.
module supply_front_panel_controller_top_tb;
    import spfc_pkg::*;

    localparam int CycleLimit = 40000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    in_item_t                 in_data = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    out_item_t                out_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [15:0]              cfg_data = '0;

    supply_front_panel_controller_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Panel model: mode, entry flag, hold counter, setpoints, lamps and settings.
    mode_t       pnl_mode  = MODE_STANDBY;
    logic        pnl_entry = 1'b1;
    logic [15:0] pnl_hold  = '0;
    logic [15:0] pnl_volt  = '0;
    logic [15:0] pnl_amp   = '0;
    ind_t        pnl_ind   = '0;
    cfg_t        panel_cfg;

    in_item_t    tick_queue[$];
    out_item_t   panel_expect[$];

    int ticks_queued    = 0;
    int readouts_seen   = 0;
    int mismatches      = 0;
    int trips_taken     = 0;
    int settings_loaded = 0;
    int cycles          = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    logic [7:0] modes_seen = '0;

    initial begin
        forever #6 clk = ~clk;
    end

    task automatic advance_panel(input in_item_t t, output out_item_t res);
        mode_t m;
        m = pnl_mode;
        if (t.overcurrent && (m == MODE_POWERED || m == MODE_ONCUR || m == MODE_ONVOLT))
        begin
            m = MODE_TRIPPED;
            pnl_ind.relay = 1'b0;
            trips_taken++;
        end
        if (!t.switch_on)
            m = MODE_STANDBY;
        case (m)
            MODE_STANDBY:
            begin
                if (pnl_entry)
                begin
                    pnl_ind      = '0;
                    pnl_ind.stby = 1'b1;
                    pnl_volt     = panel_cfg.voltage_default;
                    pnl_amp      = panel_cfg.current_default;
                end
                if (t.switch_on) m = MODE_MENU;
            end
            MODE_MENU:
            begin
                if (pnl_entry)
                begin
                    pnl_ind      = '0;
                    pnl_ind.blue = 1'b1;
                end
                if (t.press_enter) m = MODE_POWERED;
                if (t.press_up)    m = MODE_VOLTCFG;
                if (t.press_down)  m = MODE_CURCFG;
            end
            MODE_POWERED:
            begin
                if (pnl_entry)
                begin
                    pnl_ind       = '0;
                    pnl_ind.out   = 1'b1;
                    pnl_ind.relay = 1'b1;
                    pnl_ind.green = 1'b1;
                end
                if (t.press_enter) m = MODE_MENU;
                if (t.press_up)    m = MODE_ONVOLT;
                if (t.press_down)  m = MODE_ONCUR;
                if (t.press_back)  m = MODE_MENU;
            end
            MODE_TRIPPED:
            begin
                if (pnl_entry)
                begin
                    pnl_ind      = '0;
                    pnl_ind.trip = 1'b1;
                    pnl_ind.red  = 1'b1;
                end
                if (pnl_hold != 16'hFFFF) pnl_hold = pnl_hold + 16'd1;
                if (pnl_hold >= panel_cfg.trip_hold_ticks) m = MODE_MENU;
            end
            MODE_CURCFG, MODE_ONCUR:
            begin
                if (t.press_up && pnl_amp < panel_cfg.current_max)
                    pnl_amp = pnl_amp + 16'd1;
                if (t.press_down && pnl_amp > panel_cfg.current_min)
                    pnl_amp = pnl_amp - 16'd1;
                if (m == MODE_CURCFG)
                begin
                    if (t.press_back)  m = MODE_MENU;
                    if (t.press_enter) m = MODE_POWERED;
                end
                else
                begin
                    if (t.press_back)  m = MODE_POWERED;
                    if (t.press_enter) m = MODE_MENU;
                end
            end
            default:
            begin
                if (t.press_up && pnl_volt < panel_cfg.voltage_max)
                    pnl_volt = pnl_volt + 16'd1;
                if (t.press_down && pnl_volt > panel_cfg.voltage_min)
                    pnl_volt = pnl_volt - 16'd1;
                if (m == MODE_VOLTCFG)
                begin
                    if (t.press_back)  m = MODE_MENU;
                    if (t.press_enter) m = MODE_POWERED;
                end
                else
                begin
                    if (t.press_back)  m = MODE_POWERED;
                    if (t.press_enter) m = MODE_MENU;
                end
            end
        endcase
        // a mode change arms the entry action for the next tick
        pnl_entry = (m != pnl_mode);
        if (m != pnl_mode) pnl_hold = '0;
        pnl_mode = m;

        res.mode             = m;
        res.relay_closed     = pnl_ind.relay;
        res.standby_lamp     = pnl_ind.stby;
        res.output_lamp      = pnl_ind.out;
        res.trip_lamp        = pnl_ind.trip;
        res.glow_red         = pnl_ind.red;
        res.glow_green       = pnl_ind.green;
        res.glow_blue        = pnl_ind.blue;
        res.voltage_setpoint = pnl_volt;
        res.current_setpoint = pnl_amp;
    endtask

    // Tick source: hold a stalled item, otherwise take the next one or idle.
    always @(posedge clk)
    begin : drive_ticks
        out_item_t res;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_panel(in_data, res);
                panel_expect.push_back(res);
                modes_seen[res.mode] = 1'b1;
            end
            if (!in_valid || !in_stall)
            begin
                if (tick_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= tick_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Readout checker and receiver stalls.
    always @(posedge clk)
    begin : check_readouts
        out_item_t want;
        string     what;
        if (rst_n && out_valid && !out_stall)
        begin
            if (panel_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected readout: mode %0d v %0d a %0d",
                             out_data.mode, out_data.voltage_setpoint,
                             out_data.current_setpoint);
            end
            else
            begin
                want = panel_expect.pop_front();
                readouts_seen++;
                what = "";
                if (out_data.mode !== want.mode)                         what = {what, " mode"};
                if (out_data.relay_closed !== want.relay_closed)         what = {what, " relay"};
                if (out_data.standby_lamp !== want.standby_lamp)         what = {what, " stby"};
                if (out_data.output_lamp !== want.output_lamp)           what = {what, " out"};
                if (out_data.trip_lamp !== want.trip_lamp)               what = {what, " trip"};
                if (out_data.glow_red !== want.glow_red)                 what = {what, " red"};
                if (out_data.glow_green !== want.glow_green)             what = {what, " green"};
                if (out_data.glow_blue !== want.glow_blue)               what = {what, " blue"};
                if (out_data.voltage_setpoint !== want.voltage_setpoint) what = {what, " volt"};
                if (out_data.current_setpoint !== want.current_setpoint) what = {what, " amp"};
                if (what != "")
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("readout %0d bad:%s | want m%0d lamps %b v%0d a%0d",
                               readouts_seen, what,
                               want.mode, want[38:32], want.voltage_setpoint,
                               want.current_setpoint);
                        $display(" | got m%0d lamps %b v%0d a%0d",
                                 out_data.mode, out_data[38:32],
                                 out_data.voltage_setpoint, out_data.current_setpoint);
                    end
                end
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d of %0d readouts seen",
                     cycles, readouts_seen, ticks_queued);
            $display("supply_front_panel_controller_top_tb NOT OK");
            $finish;
        end
    end

    task automatic queue_tick(input bit sw, oc, ent, up, dn, bk);
        tick_queue.push_back({sw, oc, ent, up, dn, bk});
        ticks_queued++;
    endtask

    // Mostly switch held on with sparse faults and presses; some pure noise.
    task automatic queue_random_ticks(input int n);
        in_item_t t;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                t = in_item_t'(6'($urandom_range(63)));
            else
            begin
                t.switch_on   = $urandom_range(99) >= 3;
                t.overcurrent = $urandom_range(99) < 5;
                t.press_enter = $urandom_range(99) < 22;
                t.press_up    = $urandom_range(99) < 22;
                t.press_down  = $urandom_range(99) < 22;
                t.press_back  = $urandom_range(99) < 22;
            end
            tick_queue.push_back(t);
            ticks_queued++;
        end
    endtask

    // Wait until every queued tick has produced its readout, then let it settle.
    task automatic wait_idle();
        while (readouts_seen != ticks_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Call on a rising edge; returns on the edge that takes the write.
    task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_VOLTAGE_MAX:     panel_cfg.voltage_max     = val;
            CFG_VOLTAGE_MIN:     panel_cfg.voltage_min     = val;
            CFG_CURRENT_MAX:     panel_cfg.current_max     = val;
            CFG_CURRENT_MIN:     panel_cfg.current_min     = val;
            CFG_TRIP_HOLD_TICKS: panel_cfg.trip_hold_ticks = val;
            CFG_VOLTAGE_DEFAULT: panel_cfg.voltage_default = val;
            CFG_CURRENT_DEFAULT: panel_cfg.current_default = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] v_max, v_min, c_max, c_min,
                                 input logic [15:0] hold, v_def, c_def);
        cfg_write(CFG_VOLTAGE_MAX, v_max);
        cfg_write(CFG_VOLTAGE_MIN, v_min);
        cfg_write(CFG_CURRENT_MAX, c_max);
        cfg_write(CFG_CURRENT_MIN, c_min);
        cfg_write(CFG_TRIP_HOLD_TICKS, hold);
        cfg_write(CFG_VOLTAGE_DEFAULT, v_def);
        cfg_write(CFG_CURRENT_DEFAULT, c_def);
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    initial
    begin : stimulus
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 70, 0, 28};
        stall_tab = '{0, 0, 70, 28};
        panel_cfg = {VoltageMaxReset, VoltageMinReset, CurrentMaxReset, CurrentMinReset,
                     TripHoldTicksReset, VoltageDefaultReset, CurrentDefaultReset};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the menus on reset settings.
        queue_tick(0, 0, 0, 0, 0, 0);  // standby entry loads the defaults
        queue_tick(1, 0, 0, 0, 0, 0);
        queue_tick(1, 1, 0, 0, 0, 0);  // overcurrent in menu is ignored
        queue_tick(1, 0, 1, 1, 1, 1);  // all buttons at once: down wins
        queue_tick(1, 0, 0, 1, 1, 0);
        queue_tick(1, 0, 0, 0, 1, 0);
        queue_tick(1, 0, 1, 0, 0, 1);  // back then enter: enter wins
        queue_tick(1, 0, 0, 0, 0, 0);
        queue_tick(1, 0, 0, 1, 0, 0);
        queue_tick(1, 0, 0, 1, 0, 0);
        queue_tick(1, 0, 0, 0, 1, 1);
        queue_tick(1, 0, 0, 0, 1, 0);
        queue_tick(1, 0, 1, 0, 0, 1);
        queue_tick(1, 0, 0, 1, 0, 0);
        repeat (6) queue_tick(1, 0, 0, 0, 1, 0);  // run the voltage into its floor
        queue_tick(1, 0, 1, 0, 0, 0);
        queue_tick(1, 0, 0, 0, 0, 0);
        queue_tick(1, 1, 1, 0, 0, 0);  // trip while powered
        queue_tick(1, 0, 0, 0, 0, 0);
        queue_tick(1, 1, 0, 0, 0, 0);
        queue_tick(0, 1, 0, 0, 0, 0);  // switch released while tripped
        queue_tick(0, 0, 0, 0, 0, 0);
        queue_tick(1, 0, 0, 0, 0, 0);
        queue_tick(1, 0, 1, 0, 0, 0);
        queue_tick(1, 0, 0, 1, 0, 0);
        queue_tick(0, 1, 0, 0, 0, 0);  // trip and release in the same tick
        queue_random_ticks(120);
        wait_idle();

        sender_idle_pct = 70;
        receiver_stall_pct = 0;
        load_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'd0);
        queue_random_ticks(120);
        wait_idle();

        // inverted clamps
        sender_idle_pct = 0;
        receiver_stall_pct = 70;
        load_settings(16'd3, 16'd10, 16'd0, 16'hFFFF, 16'd2, 16'd7, 16'hFFFF);
        queue_random_ticks(120);
        wait_idle();

        sender_idle_pct = 28;
        receiver_stall_pct = 28;
        load_settings(16'd12, 16'd8, 16'd360, 16'd340, 16'd5, 16'd10, 16'd350);
        queue_random_ticks(120);
        wait_idle();

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd3, 16'd0, 16'd0);
        queue_random_ticks(120);
        wait_idle();

        // Long hold: trip from powered and sit it out with buttons rattling.
        load_settings(16'd30, 16'd0, 16'd3000, 16'd0, 16'd120, 16'd5, 16'd350);
        queue_tick(0, 0, 0, 0, 0, 0);
        queue_tick(1, 0, 0, 0, 0, 0);
        queue_tick(1, 0, 1, 0, 0, 0);
        queue_tick(1, 1, 0, 0, 0, 0);
        for (int i = 0; i < 130; i++)
            queue_tick(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
        wait_idle();

        for (int k = 0; k < 4; k++)
        begin
            sender_idle_pct = idle_tab[k];
            receiver_stall_pct = stall_tab[k];
            if (k == 0)
                load_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535, 1)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535)));
            else
                load_settings(16'($urandom_range(40)), 16'($urandom_range(40)),
                              16'($urandom_range(400)), 16'($urandom_range(400)),
                              16'($urandom_range(25, 1)), 16'($urandom_range(40)),
                              16'($urandom_range(400)));
            queue_random_ticks(120);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (panel_expect.size() != 0)
        begin
            $display("%0d readouts never arrived", panel_expect.size());
            mismatches += panel_expect.size();
        end
        $display("checked %0d panel ticks over %0d settings, %0d overcurrent trips",
                 readouts_seen, settings_loaded, trips_taken);
        $display("modes reached %b, %0d mismatches", modes_seen, mismatches);
        if (mismatches == 0)
            $display("supply_front_panel_controller_top_tb OK");
        else
            $display("supply_front_panel_controller_top_tb NOT OK");
        $finish;
    end

endmodule
